FILE: design/bfdh_pkg.sv
// shared types and constants for the double-hash bloom filter
`default_nettype none

package bfdh_pkg;

  // fixed field widths
  localparam int unsigned HalfW       = 32;
  localparam int unsigned KeyHashW    = 2 * HalfW;
  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned ByteSelW    = $clog2(BitsPerByte);
  localparam int unsigned BitsInUseW  = 17;
  localparam int unsigned HashCountW  = 5;

  // configuration port
  localparam int unsigned CfgIndexW = 4;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [CfgIndexW-1:0] CfgBitsInUse = CfgIndexW'(0);
  localparam logic [CfgIndexW-1:0] CfgHashCount = CfgIndexW'(1);

  localparam logic [BitsInUseW-1:0] BitsInUseRst = BitsInUseW'(65536);
  localparam logic [HashCountW-1:0] HashCountRst = HashCountW'(7);

  // default sizes
  localparam int unsigned DefMaxFilterBits = 65536;
  localparam int unsigned DefMaxHashCount  = 16;

  // operation codes
  localparam logic OpInsert = 1'b0;
  localparam logic OpQuery  = 1'b1;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StReduce,
    StRead,
    StCheck,
    StDone
  } state_e;

endpackage : bfdh_pkg

`default_nettype wire

FILE: design/bfdh_addmod.sv
// shared modular add unit: (a + b + cin) mod m, for a and b below m
`default_nettype none

module bfdh_addmod #(
  parameter int unsigned MAX_FILTER_BITS = bfdh_pkg::DefMaxFilterBits
) (
  input  wire logic [$clog2(MAX_FILTER_BITS+1)-1:0] a_i,
  input  wire logic [$clog2(MAX_FILTER_BITS+1)-1:0] b_i,
  input  wire logic                                 cin_i,
  input  wire logic [$clog2(MAX_FILTER_BITS+1)-1:0] m_i,
  output logic      [$clog2(MAX_FILTER_BITS+1)-1:0] res_o
);

  localparam int unsigned MW = $clog2(MAX_FILTER_BITS + 1);

  logic [MW:0] sum;
  logic [MW:0] diff;

  always_comb begin
    sum  = {1'b0, a_i} + {1'b0, b_i} + {{MW{1'b0}}, cin_i};
    diff = sum - {1'b0, m_i};
    // sum stays below 2m, so one subtract is enough
    if (sum >= {1'b0, m_i}) begin
      res_o = diff[MW-1:0];
    end else begin
      res_o = sum[MW-1:0];
    end
  end

endmodule : bfdh_addmod

`default_nettype wire

FILE: design/bfdh_store.sv
// byte-wide filter bit store, one write port and one registered read port
`default_nettype none

module bfdh_store #(
  parameter int unsigned MAX_FILTER_BITS = bfdh_pkg::DefMaxFilterBits,
  localparam int unsigned Depth =
    (MAX_FILTER_BITS + bfdh_pkg::BitsPerByte - 1) / bfdh_pkg::BitsPerByte,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic [AW-1:0]            addr_i,
  input  wire logic                     we_i,
  input  wire logic [bfdh_pkg::BitsPerByte-1:0] wdata_i,
  output logic      [bfdh_pkg::BitsPerByte-1:0] rdata_o
);

  logic [bfdh_pkg::BitsPerByte-1:0] mem [Depth];
  logic [bfdh_pkg::BitsPerByte-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule : bfdh_store

`default_nettype wire

FILE: design/bfdh_ctrl.sv
// sequencer: clear sweep, hash reduction and per-index store access
`default_nettype none

module bfdh_ctrl #(
  parameter int unsigned MAX_FILTER_BITS = bfdh_pkg::DefMaxFilterBits,
  parameter int unsigned MAX_HASH_COUNT  = bfdh_pkg::DefMaxHashCount,
  localparam int unsigned MW    = $clog2(MAX_FILTER_BITS + 1),
  localparam int unsigned KW    = $clog2(MAX_HASH_COUNT + 1),
  localparam int unsigned Depth =
    (MAX_FILTER_BITS + bfdh_pkg::BitsPerByte - 1) / bfdh_pkg::BitsPerByte,
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input word
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              in_op_i,
  input  wire logic [bfdh_pkg::KeyHashW-1:0]     in_key_hash_i,
  // result word
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   out_maybe_present_o,
  // effective configuration
  input  wire logic [MW-1:0]                     m_eff_i,
  input  wire logic [KW-1:0]                     k_eff_i,
  // shared add unit
  output logic      [MW-1:0]                     unit_a_o,
  output logic      [MW-1:0]                     unit_b_o,
  output logic                                   unit_cin_o,
  input  wire logic [MW-1:0]                     unit_res_i,
  // bit store
  output logic      [AW-1:0]                     mem_addr_o,
  output logic                                   mem_we_o,
  output logic      [bfdh_pkg::BitsPerByte-1:0]  mem_wdata_o,
  input  wire logic [bfdh_pkg::BitsPerByte-1:0]  mem_rdata_i
);

  localparam int unsigned RedCycles = bfdh_pkg::KeyHashW;
  localparam int unsigned RcW   = $clog2(RedCycles);
  localparam logic [AW-1:0]  ClrLast = AW'(Depth - 1);
  localparam logic [RcW-1:0] RedMid  = RcW'(bfdh_pkg::HalfW - 1);
  localparam logic [RcW-1:0] RedLast = RcW'(RedCycles - 1);

  bfdh_pkg::state_e state_q, state_d;

  logic [AW-1:0]                    clr_q;
  logic [RcW-1:0]                   red_cnt_q;
  logic [KW-1:0]                    hash_cnt_q;
  logic [bfdh_pkg::KeyHashW-1:0]    sh_q;
  logic [MW-1:0]                    acc_q;
  logic [MW-1:0]                    idx_q;
  logic [MW-1:0]                    step_q;
  logic                             op_q;
  logic                             all_set_q;
  logic                             out_valid_q;
  logic                             out_mp_q;
  logic                             out_load;
  logic                             last_hash;
  logic [AW-1:0]                    byte_addr;
  logic [bfdh_pkg::BitsPerByte-1:0] bit_mask;

  assign byte_addr = AW'(idx_q >> bfdh_pkg::ByteSelW);
  assign bit_mask  = bfdh_pkg::BitsPerByte'(1) << idx_q[bfdh_pkg::ByteSelW-1:0];
  assign last_hash = (hash_cnt_q + KW'(1)) == k_eff_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfdh_pkg::StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    mem_addr_o  = byte_addr;
    mem_we_o    = 1'b0;
    mem_wdata_o = mem_rdata_i | bit_mask;
    unit_a_o    = acc_q;
    unit_b_o    = acc_q;
    unit_cin_o  = sh_q[bfdh_pkg::KeyHashW-1];
    out_load    = 1'b0;
    case (state_q)
      bfdh_pkg::StClear: begin
        mem_addr_o  = clr_q;
        mem_we_o    = 1'b1;
        mem_wdata_o = '0;
        if (clr_q == ClrLast) begin
          state_d = bfdh_pkg::StIdle;
        end
      end
      bfdh_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = bfdh_pkg::StReduce;
        end
      end
      bfdh_pkg::StReduce: begin
        // remainder = 2*remainder + next hash bit, folded back below m
        if (red_cnt_q == RedLast) begin
          state_d = bfdh_pkg::StRead;
        end
      end
      bfdh_pkg::StRead: begin
        state_d = bfdh_pkg::StCheck;
      end
      bfdh_pkg::StCheck: begin
        unit_a_o   = idx_q;
        unit_b_o   = step_q;
        unit_cin_o = 1'b0;
        mem_we_o   = (op_q == bfdh_pkg::OpInsert);
        if (last_hash) begin
          state_d = bfdh_pkg::StDone;
        end else begin
          state_d = bfdh_pkg::StRead;
        end
      end
      bfdh_pkg::StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = bfdh_pkg::StIdle;
        end
      end
      default: begin
        state_d = bfdh_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (state_q == bfdh_pkg::StClear) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      bfdh_pkg::StIdle: begin
        if (in_valid_i) begin
          op_q       <= in_op_i;
          // h1 shifted in first, then h2
          sh_q       <= {in_key_hash_i[bfdh_pkg::HalfW-1:0],
                         in_key_hash_i[bfdh_pkg::KeyHashW-1:bfdh_pkg::HalfW]};
          acc_q      <= '0;
          red_cnt_q  <= '0;
          hash_cnt_q <= '0;
          all_set_q  <= 1'b1;
        end
      end
      bfdh_pkg::StReduce: begin
        sh_q      <= sh_q << 1;
        red_cnt_q <= red_cnt_q + RcW'(1);
        if (red_cnt_q == RedMid) begin
          idx_q <= unit_res_i;
          acc_q <= '0;
        end else begin
          acc_q <= unit_res_i;
        end
        if (red_cnt_q == RedLast) begin
          step_q <= unit_res_i;
        end
      end
      bfdh_pkg::StCheck: begin
        if (op_q == bfdh_pkg::OpQuery &&
            !mem_rdata_i[idx_q[bfdh_pkg::ByteSelW-1:0]]) begin
          all_set_q <= 1'b0;
        end
        idx_q      <= unit_res_i;
        hash_cnt_q <= hash_cnt_q + KW'(1);
      end
      default: begin
      end
    endcase
  end

  // output register parts the result side from the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mp_q <= (op_q == bfdh_pkg::OpQuery) && all_set_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_maybe_present_o = out_mp_q;

endmodule : bfdh_ctrl

`default_nettype wire

FILE: design/bloom_filter_double_hash_core.sv
// top level of the double-hash bloom filter: config registers and unit wiring
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------
//   in      | to core   | in_valid_i / in_stall_o | in_op_i, in_key_hash_i
//   out     | from core | out_valid_o / out_stall_i | out_maybe_present_o
//   cfg     | to core   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// per word the shared add-mod unit reduces h1 and h2 one bit a cycle, then each index
// needs a store read and a check/write step on the single store port
// after reset the store is swept to zero, one byte a cycle over all ceil(MAX_FILTER_BITS/8)
// bytes (8192 by default), with in_stall_o high; config writes are taken anytime
// a finished result sits in the output register while the next word is accepted
`default_nettype none

module bloom_filter_double_hash_core #(
  parameter int unsigned MAX_FILTER_BITS = bfdh_pkg::DefMaxFilterBits,
  parameter int unsigned MAX_HASH_COUNT  = bfdh_pkg::DefMaxHashCount
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           in_op_i,
  input  wire logic [bfdh_pkg::KeyHashW-1:0]  in_key_hash_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                out_maybe_present_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [bfdh_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [bfdh_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned MW    = $clog2(MAX_FILTER_BITS + 1);
  localparam int unsigned KW    = $clog2(MAX_HASH_COUNT + 1);
  localparam int unsigned Depth =
    (MAX_FILTER_BITS + bfdh_pkg::BitsPerByte - 1) / bfdh_pkg::BitsPerByte;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned MCmpW = (MW > bfdh_pkg::BitsInUseW) ? MW : bfdh_pkg::BitsInUseW;
  localparam int unsigned KCmpW = (KW > bfdh_pkg::HashCountW) ? KW : bfdh_pkg::HashCountW;

  logic [bfdh_pkg::BitsInUseW-1:0] bits_in_use_q;
  logic [bfdh_pkg::HashCountW-1:0] hash_count_q;
  logic [MW-1:0]                   m_eff;
  logic [KW-1:0]                   k_eff;

  logic [MW-1:0]                    unit_a;
  logic [MW-1:0]                    unit_b;
  logic                             unit_cin;
  logic [MW-1:0]                    unit_res;
  logic [AW-1:0]                    mem_addr;
  logic                             mem_we;
  logic [bfdh_pkg::BitsPerByte-1:0] mem_wdata;
  logic [bfdh_pkg::BitsPerByte-1:0] mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_in_use_q <= bfdh_pkg::BitsInUseRst;
      hash_count_q  <= bfdh_pkg::HashCountRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bfdh_pkg::CfgBitsInUse: bits_in_use_q <= cfg_data_i[bfdh_pkg::BitsInUseW-1:0];
        bfdh_pkg::CfgHashCount: hash_count_q  <= cfg_data_i[bfdh_pkg::HashCountW-1:0];
        default: begin
        end
      endcase
    end
  end

  // zero means one, anything above the maximum saturates
  always_comb begin
    if (bits_in_use_q == '0) begin
      m_eff = MW'(1);
    end else if (MCmpW'(bits_in_use_q) > MCmpW'(MAX_FILTER_BITS)) begin
      m_eff = MW'(MAX_FILTER_BITS);
    end else begin
      m_eff = MW'(bits_in_use_q);
    end
    if (hash_count_q == '0) begin
      k_eff = KW'(1);
    end else if (KCmpW'(hash_count_q) > KCmpW'(MAX_HASH_COUNT)) begin
      k_eff = KW'(MAX_HASH_COUNT);
    end else begin
      k_eff = KW'(hash_count_q);
    end
  end

  bfdh_addmod #(
    .MAX_FILTER_BITS(MAX_FILTER_BITS)
  ) u_addmod (
    .a_i  (unit_a),
    .b_i  (unit_b),
    .cin_i(unit_cin),
    .m_i  (m_eff),
    .res_o(unit_res)
  );

  bfdh_store #(
    .MAX_FILTER_BITS(MAX_FILTER_BITS)
  ) u_store (
    .clk_i  (clk_i),
    .addr_i (mem_addr),
    .we_i   (mem_we),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  bfdh_ctrl #(
    .MAX_FILTER_BITS(MAX_FILTER_BITS),
    .MAX_HASH_COUNT (MAX_HASH_COUNT)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_op_i            (in_op_i),
    .in_key_hash_i      (in_key_hash_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_maybe_present_o(out_maybe_present_o),
    .m_eff_i            (m_eff),
    .k_eff_i            (k_eff),
    .unit_a_o           (unit_a),
    .unit_b_o           (unit_b),
    .unit_cin_o         (unit_cin),
    .unit_res_i         (unit_res),
    .mem_addr_o         (mem_addr),
    .mem_we_o           (mem_we),
    .mem_wdata_o        (mem_wdata),
    .mem_rdata_i        (mem_rdata)
  );

endmodule : bloom_filter_double_hash_core

`default_nettype wire
